FILE: rtl/ibps_pkg.sv
// ----------------------------------------------------------------------------
// ibps_pkg
// Shared types and constants of the incoherent beam power sum block.
// ----------------------------------------------------------------------------
package ibps_pkg;

  // Accumulator word and its saturation level
  localparam int unsigned ACC_W     = 15;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Power of one beat: two polarizations, each re^2 + im^2 <= 128
  localparam int unsigned POW_W     = 9;

  // Restoring divider: one quotient bit per step
  localparam int unsigned DIV_CNT_W = $clog2(ACC_W);

  // Field widths
  localparam int unsigned BEAM_W      = 8;
  localparam int unsigned CHAN_IDX_W  = 9;
  localparam int unsigned TIME_IDX_W  = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_USED_W  = BEAM_W + CHAN_IDX_W + TIME_IDX_W;
  localparam int unsigned OUT_TDATA_W = 24;

  // Configuration register widths and reset values
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned ANT_REG_W   = 7;
  localparam int unsigned CHAN_REG_W  = 10;
  localparam int unsigned TIME_REG_W  = 3;
  localparam logic [ANT_REG_W-1:0]  USED_ANT_RST   = 7'd24;
  localparam logic [ANT_REG_W-1:0]  TOTAL_ANT_RST  = 7'd24;
  localparam logic [CHAN_REG_W-1:0] CHAN_COUNT_RST = 10'd384;
  localparam logic [TIME_REG_W-1:0] TIME_COUNT_RST = 3'd2;

  typedef enum logic [1:0] {
    REG_USED_ANT,
    REG_TOTAL_ANT,
    REG_CHAN_COUNT,
    REG_TIME_COUNT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_PUSH
  } state_t;

endpackage

FILE: rtl/incoherent_beam_power_sum.sv
// ----------------------------------------------------------------------------
// incoherent_beam_power_sum
// Incoherent beamformer: power of 4-bit complex dual-pol voltages summed over
// the leading antennas of a frame, mean emitted per channel/time cell.
// ----------------------------------------------------------------------------
// One beat enters at a time. A beat that belongs to a skipped antenna needs
// only the idle state. A beat that only adds into its cell passes the idle
// state, which reads the cell's accumulator from the registered-read memory,
// and the RMW state, which adds and writes it back. A beat of the last used
// antenna of a cell adds 15 steps of the restoring divider (one quotient bit
// per step, one shared subtractor) and the push state, which moves the mean
// into the output register. The output register holds a finished result
// while the next beats are taken; only when the divider finishes with the
// output register still full does the block wait for out_tready. The
// accumulator memory needs no clearing pass: the first antenna of a cell
// overwrites its entry. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module incoherent_beam_power_sum #(
  parameter int unsigned MAX_CHANNELS = 512,
  parameter int unsigned MAX_TIMES    = 4,
  parameter int unsigned MAX_ANTENNAS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ibps_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] sample_x, [15:8] sample_y
  input  logic [ibps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] beam_power, [16:8] channel_index, [18:17] time_index, [23:19] zero
  output logic [ibps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // frame_end
  output logic                              out_tlast
);

  localparam int unsigned ACC_W     = ibps_pkg::ACC_W;
  localparam int unsigned POW_W     = ibps_pkg::POW_W;
  localparam int unsigned AP_W      = (MAX_ANTENNAS > 1) ? $clog2(MAX_ANTENNAS) : 1;
  localparam int unsigned CP_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned TP_W      = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
  localparam int unsigned AC_W      = $clog2(MAX_ANTENNAS + 1);
  localparam int unsigned CC_W      = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned TC_W      = $clog2(MAX_TIMES + 1);
  localparam int unsigned ACC_DEPTH = MAX_CHANNELS * MAX_TIMES;
  localparam int unsigned ADDR_W    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int unsigned DW        = AC_W;

  // Power of one byte: low nibble signed real, high nibble signed imaginary
  function automatic logic [7:0] byte_power(input logic [7:0] b);
    logic signed [3:0] re;
    logic signed [3:0] im;
    logic signed [7:0] re2;
    logic signed [7:0] im2;
    re  = b[3:0];
    im  = b[7:4];
    re2 = re * re;
    im2 = im * im;
    return 8'(unsigned'(re2)) + 8'(unsigned'(im2));
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers (always ready)
  // ---------------------------------------------------------------------
  logic [ibps_pkg::ANT_REG_W-1:0]  used_ant_r;
  logic [ibps_pkg::ANT_REG_W-1:0]  total_ant_r;
  logic [ibps_pkg::CHAN_REG_W-1:0] chan_count_r;
  logic [ibps_pkg::TIME_REG_W-1:0] time_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_ant_r   <= ibps_pkg::USED_ANT_RST;
      total_ant_r  <= ibps_pkg::TOTAL_ANT_RST;
      chan_count_r <= ibps_pkg::CHAN_COUNT_RST;
      time_count_r <= ibps_pkg::TIME_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ibps_pkg::cfg_reg_t'(cfg_index))
        ibps_pkg::REG_USED_ANT:   used_ant_r   <= cfg_data[ibps_pkg::ANT_REG_W-1:0];
        ibps_pkg::REG_TOTAL_ANT:  total_ant_r  <= cfg_data[ibps_pkg::ANT_REG_W-1:0];
        ibps_pkg::REG_CHAN_COUNT: chan_count_r <= cfg_data[ibps_pkg::CHAN_REG_W-1:0];
        ibps_pkg::REG_TIME_COUNT: time_count_r <= cfg_data[ibps_pkg::TIME_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to 1..MAX; a frame holds at least the used antennas
  logic [AC_W-1:0] ua;
  logic [AC_W-1:0] ta_raw;
  logic [AC_W-1:0] ta;
  logic [CC_W-1:0] nc;
  logic [TC_W-1:0] nt;

  always_comb begin
    if (used_ant_r == '0)
      ua = AC_W'(1);
    else if (32'(used_ant_r) > 32'(MAX_ANTENNAS))
      ua = AC_W'(MAX_ANTENNAS);
    else
      ua = AC_W'(used_ant_r);

    if (total_ant_r == '0)
      ta_raw = AC_W'(1);
    else if (32'(total_ant_r) > 32'(MAX_ANTENNAS))
      ta_raw = AC_W'(MAX_ANTENNAS);
    else
      ta_raw = AC_W'(total_ant_r);
    ta = (ta_raw < ua) ? ua : ta_raw;

    if (chan_count_r == '0)
      nc = CC_W'(1);
    else if (32'(chan_count_r) > 32'(MAX_CHANNELS))
      nc = CC_W'(MAX_CHANNELS);
    else
      nc = CC_W'(chan_count_r);

    if (time_count_r == '0)
      nt = TC_W'(1);
    else if (32'(time_count_r) > 32'(MAX_TIMES))
      nt = TC_W'(MAX_TIMES);
    else
      nt = TC_W'(time_count_r);
  end

  // ---------------------------------------------------------------------
  // Control state machine
  // ---------------------------------------------------------------------
  ibps_pkg::state_t state_r, state_nxt;

  logic in_fire;
  logic div_run;
  logic div_done;
  logic push;
  logic rmw_en;
  // Beat lands in the accumulator only for a used antenna
  logic ap_used;

  logic                            used_r;
  logic                            first_r;
  logic                            last_r;
  logic                            fend_r;
  logic [CP_W-1:0]                 ch_r;
  logic [TP_W-1:0]                 tm_r;
  logic [POW_W-1:0]                pow_r;
  logic [ADDR_W-1:0]               addr_r;
  logic [ibps_pkg::DIV_CNT_W-1:0]  div_cnt_r;
  logic                            out_valid_r;

  assign in_fire  = in_tvalid && in_tready;
  assign div_done = (32'(div_cnt_r) == ACC_W - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ibps_pkg::ST_IDLE: if (in_fire && ap_used) state_nxt = ibps_pkg::ST_RMW;
      ibps_pkg::ST_RMW:  state_nxt = last_r ? ibps_pkg::ST_DIV : ibps_pkg::ST_IDLE;
      ibps_pkg::ST_DIV:  if (div_done) state_nxt = ibps_pkg::ST_PUSH;
      ibps_pkg::ST_PUSH: if (!out_valid_r || out_tready) state_nxt = ibps_pkg::ST_IDLE;
      default:           state_nxt = ibps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rmw_en    = 1'b0;
    div_run   = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      ibps_pkg::ST_IDLE: in_tready = 1'b1;
      ibps_pkg::ST_RMW:  rmw_en    = 1'b1;
      ibps_pkg::ST_DIV:  div_run   = 1'b1;
      ibps_pkg::ST_PUSH: push      = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ibps_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------
  // Frame positions: time fastest, then channel, then antenna
  // ---------------------------------------------------------------------
  logic [AP_W-1:0] ap_r, ap_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic [TP_W-1:0] tp_r, tp_nxt;
  logic            t_wrap, c_wrap, a_wrap;

  assign t_wrap  = (32'(tp_r) + 32'd1) >= 32'(nt);
  assign c_wrap  = (32'(cp_r) + 32'd1) >= 32'(nc);
  assign a_wrap  = (32'(ap_r) + 32'd1) >= 32'(ta);
  assign ap_used = 32'(ap_r) < 32'(ua);

  always_comb begin
    ap_nxt = ap_r;
    cp_nxt = cp_r;
    tp_nxt = tp_r;
    if (t_wrap) begin
      tp_nxt = '0;
      if (c_wrap) begin
        cp_nxt = '0;
        ap_nxt = a_wrap ? '0 : ap_r + AP_W'(1);
      end else begin
        cp_nxt = cp_r + CP_W'(1);
      end
    end else begin
      tp_nxt = tp_r + TP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r <= '0;
      cp_r <= '0;
      tp_r <= '0;
    end else if (in_fire) begin
      ap_r <= ap_nxt;
      cp_r <= cp_nxt;
      tp_r <= tp_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Capture the beat; start the accumulator read in the same edge
  // ---------------------------------------------------------------------
  logic [ADDR_W-1:0] cell_addr;

  assign cell_addr = ADDR_W'(32'(cp_r) * MAX_TIMES + 32'(tp_r));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      used_r  <= ap_used;
      first_r <= (ap_r == '0);
      last_r  <= (32'(ap_r) + 32'd1) >= 32'(ua);
      fend_r  <= c_wrap && t_wrap;
      ch_r    <= cp_r;
      tm_r    <= tp_r;
      addr_r  <= cell_addr;
      pow_r   <= POW_W'(byte_power(in_tdata[7:0])) + POW_W'(byte_power(in_tdata[15:8]));
    end
  end

  // ---------------------------------------------------------------------
  // Accumulator memory: read at accept; the next state, RMW, adds and writes back later
  // ---------------------------------------------------------------------
  logic [ACC_W-1:0] acc_mem [ACC_DEPTH];
  logic [ACC_W-1:0] rd_data_r;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_sat;

  always_ff @(posedge clk) begin
    if (in_fire) rd_data_r <= acc_mem[cell_addr];
  end

  // First antenna of a cell starts from zero
  assign acc_sum = (first_r ? '0 : {1'b0, rd_data_r}) + (ACC_W + 1)'(pow_r);
  assign acc_sat = acc_sum[ACC_W] ? ibps_pkg::ACC_MAX : acc_sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rmw_en && used_r) acc_mem[addr_r] <= acc_sat;
  end

  // ---------------------------------------------------------------------
  // Restoring divider: sum / used antennas, one quotient bit per step
  // ---------------------------------------------------------------------
  logic [ACC_W-1:0] quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic             fits;
  logic [DW:0]      diff;

  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rmw_en) begin
      quo_r <= acc_sat;
      rem_r <= '0;
      den_r <= ua;
    end else if (div_run) begin
      quo_r <= {quo_r[ACC_W-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       div_cnt_r <= '0;
    else if (rmw_en)  div_cnt_r <= '0;
    else if (div_run) div_cnt_r <= div_cnt_r + ibps_pkg::DIV_CNT_W'(1);
  end

  // ---------------------------------------------------------------------
  // Output register: hold the result until the sink takes it
  // ---------------------------------------------------------------------
  logic [ibps_pkg::BEAM_W-1:0]     beam_r;
  logic [ibps_pkg::CHAN_IDX_W-1:0] chan_idx_r;
  logic [ibps_pkg::TIME_IDX_W-1:0] time_idx_r;
  logic                            tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                 out_valid_r <= 1'b0;
    else if (push)              out_valid_r <= 1'b1;
    else if (out_tready)        out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      // Saturate the mean at 255
      beam_r     <= (quo_r > ACC_W'(255)) ? 8'hFF : quo_r[7:0];
      chan_idx_r <= ibps_pkg::CHAN_IDX_W'(ch_r);
      time_idx_r <= ibps_pkg::TIME_IDX_W'(tm_r);
      tlast_r    <= fend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ibps_pkg::OUT_TDATA_W - ibps_pkg::OUT_USED_W)'(0),
                       time_idx_r, chan_idx_r, beam_r};
  assign out_tlast  = tlast_r;

endmodule

FILE: rtl/ibps_checker.sv
// ----------------------------------------------------------------------------
// ibps_checker
// Port-level checks of the incoherent beam power sum block.
// ----------------------------------------------------------------------------
module ibps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ibps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A new result follows the divider, never an accept right before it
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared right after an input beat");

  // Padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ibps_pkg::OUT_TDATA_W-1:ibps_pkg::OUT_USED_W] == '0)
    else $error("result padding bits not zero");

endmodule

bind incoherent_beam_power_sum ibps_checker u_ibps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
